// File: sv/bcadc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcadc_pkg
// Shared types, register codes and discharge curve tables of the
// battery charge estimator.
// ----------------------------------------------------------------------------
package bcadc_pkg;

  localparam int MAX_POINTS      = 13;
  localparam int NUM_CHEMISTRIES = 7;
  localparam int PT_W            = $clog2(MAX_POINTS + 1);

  // Datapath widths
  localparam int PROD_W  = 45;               // sample * vref * divider
  localparam int NUM_W   = PROD_W - 8;       // after dropping the /256
  localparam int DEN_W   = 21;               // full_scale * cell_count
  localparam int QBITS   = 16;               // quotient bits before saturation
  localparam int RECIP_W = 27;
  localparam int DP_W    = 5;                // percent step within one segment
  localparam int OFF_W   = 8;                // mV offset within one segment

  // Cycles from an accepted transaction to its result strobe
  localparam int LATENCY = 6 + QBITS + 1;

  localparam logic [14:0] FULL_Q8 = 15'd25600;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CHEMISTRY      = 3'd0,
    REG_CELL_COUNT     = 3'd1,
    REG_VREF_MV        = 3'd2,
    REG_DIVIDER_Q8     = 3'd3,
    REG_ADC_FULL_SCALE = 3'd4
  } reg_idx_t;

  // Range status codes
  typedef enum logic [1:0] {
    RANGE_ON    = 2'd0,
    RANGE_BELOW = 2'd1,
    RANGE_ABOVE = 2'd2
  } range_t;

  typedef struct packed {
    logic [2:0]  chemistry;
    logic [4:0]  cell_count;
    logic [12:0] vref_mv;
    logic [15:0] divider_q8;
    logic [15:0] adc_full_scale;
  } cfg_t;

  localparam logic [15:0] CURVE_MV [0:NUM_CHEMISTRIES-1][0:MAX_POINTS-1] = '{
    '{16'd2500, 16'd2600, 16'd2800, 16'd3000, 16'd3200, 16'd3400, 16'd3600,
      16'd3800, 16'd3900, 16'd4000, 16'd4100, 16'd4150, 16'd4200},
    '{16'd2500, 16'd2600, 16'd2800, 16'd3000, 16'd3200, 16'd3400, 16'd3600,
      16'd3800, 16'd3900, 16'd4000, 16'd4100, 16'd4150, 16'd4200},
    '{16'd900, 16'd950, 16'd1000, 16'd1050, 16'd1100, 16'd1150, 16'd1200,
      16'd1250, 16'd1300, 16'd1350, 16'd1400, 16'd1450, 16'd0},
    '{16'd900, 16'd950, 16'd1000, 16'd1050, 16'd1100, 16'd1150, 16'd1200,
      16'd1250, 16'd1300, 16'd1350, 16'd0, 16'd0, 16'd0},
    '{16'd1750, 16'd1800, 16'd1850, 16'd1900, 16'd1950, 16'd2000, 16'd2050,
      16'd2100, 16'd2200, 16'd2270, 16'd0, 16'd0, 16'd0},
    '{16'd800, 16'd850, 16'd900, 16'd950, 16'd1000, 16'd1100, 16'd1200,
      16'd1300, 16'd1400, 16'd1500, 16'd1600, 16'd1650, 16'd0},
    '{16'd800, 16'd850, 16'd900, 16'd950, 16'd1000, 16'd1100, 16'd1200,
      16'd1300, 16'd1400, 16'd1500, 16'd1600, 16'd1650, 16'd0}
  };

  localparam logic [6:0] CURVE_PCT [0:NUM_CHEMISTRIES-1][0:MAX_POINTS-1] = '{
    '{7'd0, 7'd5, 7'd10, 7'd15, 7'd25, 7'd40, 7'd60, 7'd75, 7'd85, 7'd92,
      7'd96, 7'd99, 7'd100},
    '{7'd0, 7'd5, 7'd10, 7'd15, 7'd25, 7'd40, 7'd60, 7'd75, 7'd85, 7'd92,
      7'd96, 7'd99, 7'd100},
    '{7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90,
      7'd95, 7'd100, 7'd0},
    '{7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd85, 7'd100,
      7'd0, 7'd0, 7'd0},
    '{7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd90, 7'd100,
      7'd0, 7'd0, 7'd0},
    '{7'd0, 7'd5, 7'd10, 7'd15, 7'd25, 7'd40, 7'd60, 7'd75, 7'd85, 7'd92,
      7'd96, 7'd100, 7'd0},
    '{7'd0, 7'd5, 7'd10, 7'd15, 7'd25, 7'd40, 7'd60, 7'd75, 7'd85, 7'd92,
      7'd96, 7'd100, 7'd0}
  };

  localparam logic [PT_W-1:0] CURVE_LEN [0:NUM_CHEMISTRIES-1] = '{
    PT_W'(13), PT_W'(13), PT_W'(12), PT_W'(10), PT_W'(10), PT_W'(12), PT_W'(12)
  };

  // ceil(2^32 / span) for every segment span that occurs in the curves
  function automatic logic [RECIP_W-1:0] span_recip(input logic [OFF_W-1:0] span);
    logic [RECIP_W-1:0] r;
    unique case (span)
      8'd50:   r = 27'd85899346;
      8'd70:   r = 27'd61356676;
      8'd100:  r = 27'd42949673;
      8'd200:  r = 27'd21474837;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/bcadc_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcadc_scale
// Two multiply stages: build the voltage numerator and the divisor.
// ----------------------------------------------------------------------------
module bcadc_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [15:0]                   in_sample,
  input  bcadc_pkg::cfg_t               cfg,
  output logic                          out_vld,
  output logic [bcadc_pkg::NUM_W-1:0]   out_num,
  output logic [bcadc_pkg::DEN_W-1:0]   out_den
);

  logic                          v1_r, v2_r;
  logic [28:0]                   p1_r;
  logic [bcadc_pkg::DEN_W-1:0]   d1_r, d2_r;
  logic [bcadc_pkg::NUM_W-1:0]   n2_r;
  logic [bcadc_pkg::PROD_W-1:0]  p2_nxt;

  // Second product, drop the Q8 fraction of the divider
  assign p2_nxt = bcadc_pkg::PROD_W'(p1_r) * bcadc_pkg::PROD_W'(cfg.divider_q8);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  // Multiply payload
  always_ff @(posedge clk) begin
    p1_r <= 29'(in_sample) * 29'(cfg.vref_mv);
    d1_r <= bcadc_pkg::DEN_W'(cfg.adc_full_scale) * bcadc_pkg::DEN_W'(cfg.cell_count);
    n2_r <= p2_nxt[bcadc_pkg::PROD_W-1:8];
    d2_r <= d1_r;
  end

  assign out_vld = v2_r;
  assign out_num = n2_r;
  assign out_den = d2_r;

endmodule

// File: sv/bcadc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcadc_div
// Pipelined restoring divider, one quotient bit per stage, with saturation
// to 16 bits decided up front.
// ----------------------------------------------------------------------------
module bcadc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [bcadc_pkg::NUM_W-1:0]   in_num,
  input  logic [bcadc_pkg::DEN_W-1:0]   in_den,
  output logic                          out_vld,
  output logic [15:0]                   out_mv
);

  localparam int Q = bcadc_pkg::QBITS;

  logic                          vld_r [0:Q];
  logic                          sat_r [0:Q];
  logic [bcadc_pkg::NUM_W-1:0]   rem_r [0:Q];
  logic [bcadc_pkg::DEN_W-1:0]   den_r [0:Q];
  logic [Q-1:0]                  quo_r [0:Q];
  logic                          sat_nxt;

  // Quotient overflows 16 bits, or divisor is zero
  assign sat_nxt = (in_den == '0) ||
                   (in_num[bcadc_pkg::NUM_W-1:Q] >= in_den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= in_num;
    den_r[0] <= in_den;
    sat_r[0] <= sat_nxt;
    quo_r[0] <= '0;
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= Q; j++) begin : g_stage
    localparam int K = Q - j;
    logic [bcadc_pkg::NUM_W-1:0] sub;
    logic                        take;

    assign sub  = bcadc_pkg::NUM_W'(den_r[j-1]) << K;
    assign take = rem_r[j-1] >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= take ? rem_r[j-1] - sub : rem_r[j-1];
      quo_r[j] <= quo_r[j-1] | (Q'(take) << K);
      den_r[j] <= den_r[j-1];
      sat_r[j] <= sat_r[j-1];
    end
  end

  assign out_vld = vld_r[Q];
  assign out_mv  = sat_r[Q] ? 16'hFFFF : quo_r[Q];

endmodule

// File: sv/bcadc_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcadc_interp
// Curve lookup and linear interpolation of the charge in Q7.8 percent.
// ----------------------------------------------------------------------------
module bcadc_interp (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  logic [15:0]  in_mv,
  input  logic [2:0]   chemistry,
  output logic         out_vld,
  output logic [14:0]  out_charge,
  output logic [15:0]  out_mv,
  output logic [1:0]   out_status
);

  localparam int NP = bcadc_pkg::MAX_POINTS;

  logic [2:0]                      sel;
  logic                            found;
  logic [14:0]                     base_nxt;
  logic [bcadc_pkg::DP_W-1:0]      dp_nxt;
  logic [bcadc_pkg::OFF_W-1:0]     off_nxt;
  logic [bcadc_pkg::RECIP_W-1:0]   rcp_nxt;
  bcadc_pkg::range_t               st_nxt;
  logic [46:0]                     prod;

  logic                            v1_r, v2_r, v3_r, v4_r;
  logic [14:0]                     base1_r, base2_r, base3_r, chg4_r;
  logic [bcadc_pkg::DP_W-1:0]      dp1_r;
  logic [bcadc_pkg::OFF_W-1:0]     off1_r;
  logic [bcadc_pkg::RECIP_W-1:0]   rcp1_r, rcp2_r;
  logic [15:0]                     mv1_r, mv2_r, mv3_r, mv4_r;
  logic [1:0]                      st1_r, st2_r, st3_r, st4_r;
  logic [11:0]                     x2_r;
  logic [14:0]                     q3_r;

  // Fall back to the first curve for unknown chemistries
  assign sel = ({1'b0, chemistry} >= 4'(bcadc_pkg::NUM_CHEMISTRIES)) ? 3'd0 : chemistry;

  // Pick the first segment that holds the voltage
  always_comb begin
    found    = 1'b0;
    base_nxt = '0;
    dp_nxt   = '0;
    off_nxt  = '0;
    rcp_nxt  = '0;
    st_nxt   = bcadc_pkg::RANGE_ON;
    for (int i = 0; i < NP - 1; i++) begin
      if (!found && (bcadc_pkg::PT_W'(i + 1) < bcadc_pkg::CURVE_LEN[sel]) &&
          (in_mv >= bcadc_pkg::CURVE_MV[sel][i]) &&
          (in_mv <= bcadc_pkg::CURVE_MV[sel][i+1]) &&
          (bcadc_pkg::CURVE_MV[sel][i+1] > bcadc_pkg::CURVE_MV[sel][i])) begin
        found    = 1'b1;
        base_nxt = {bcadc_pkg::CURVE_PCT[sel][i], 8'd0};
        dp_nxt   = bcadc_pkg::DP_W'(bcadc_pkg::CURVE_PCT[sel][i+1] -
                                    bcadc_pkg::CURVE_PCT[sel][i]);
        off_nxt  = bcadc_pkg::OFF_W'(in_mv - bcadc_pkg::CURVE_MV[sel][i]);
        rcp_nxt  = bcadc_pkg::span_recip(bcadc_pkg::OFF_W'(
                     bcadc_pkg::CURVE_MV[sel][i+1] - bcadc_pkg::CURVE_MV[sel][i]));
      end
    end
    if (!found) begin
      if (in_mv < bcadc_pkg::CURVE_MV[sel][0]) begin
        st_nxt = bcadc_pkg::RANGE_BELOW;
      end else begin
        base_nxt = bcadc_pkg::FULL_Q8;
        st_nxt   = bcadc_pkg::RANGE_ABOVE;
      end
    end
  end

  // Scaled offset times reciprocal of the span
  assign prod = 47'({x2_r, 8'd0}) * 47'(rcp2_r);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Lookup, offset product, reciprocal product, final add
  always_ff @(posedge clk) begin
    base1_r <= base_nxt;
    dp1_r   <= dp_nxt;
    off1_r  <= off_nxt;
    rcp1_r  <= rcp_nxt;
    mv1_r   <= in_mv;
    st1_r   <= st_nxt;

    x2_r    <= 12'(off1_r) * 12'(dp1_r);
    rcp2_r  <= rcp1_r;
    base2_r <= base1_r;
    mv2_r   <= mv1_r;
    st2_r   <= st1_r;

    q3_r    <= prod[46:32];
    base3_r <= base2_r;
    mv3_r   <= mv2_r;
    st3_r   <= st2_r;

    chg4_r  <= base3_r + q3_r;
    mv4_r   <= mv3_r;
    st4_r   <= st3_r;
  end

  assign out_vld    = v4_r;
  assign out_charge = chg4_r;
  assign out_mv     = mv4_r;
  assign out_status = st4_r;

endmodule

// File: sv/battery_charge_from_adc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_from_adc
// Battery state of charge from one ADC sample per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with in_adc_sample; busy stays low, so a sample may be
//   given on every clock cycle.
//   Each sample yields one result: out_strobe is high for one cycle with
//   out_charge_q8 (Q7.8 percent), out_cell_millivolts and out_range_status.
//   Throughput is one sample per cycle; latency is set by the 16-stage
//   restoring divider plus two multiply stages, one saturation check stage
//   and four lookup and interpolation stages.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   is always ready; write it only while no transaction is in flight.
//   Synchronous reset empties the pipeline and loads the default
//   configuration (LiPo, one cell, 3300 mV, divider 1.0, full scale 4095).
//   The receiver cannot stall: results must be taken as they appear.
// ----------------------------------------------------------------------------
module battery_charge_from_adc (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [15:0]  in_adc_sample,
  output logic         out_strobe,
  output logic [14:0]  out_charge_q8,
  output logic [15:0]  out_cell_millivolts,
  output logic [1:0]   out_range_status,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  bcadc_pkg::cfg_t              cfg_r;
  logic                         acc;
  logic                         sc_vld, dv_vld;
  logic [bcadc_pkg::NUM_W-1:0]  sc_num;
  logic [bcadc_pkg::DEN_W-1:0]  sc_den;
  logic [15:0]                  dv_mv;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chemistry      <= 3'd0;
      cfg_r.cell_count     <= 5'd1;
      cfg_r.vref_mv        <= 13'd3300;
      cfg_r.divider_q8     <= 16'd256;
      cfg_r.adc_full_scale <= 16'd4095;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bcadc_pkg::REG_CHEMISTRY:      cfg_r.chemistry      <= cfg_data[2:0];
        bcadc_pkg::REG_CELL_COUNT:     cfg_r.cell_count     <= cfg_data[4:0];
        bcadc_pkg::REG_VREF_MV:        cfg_r.vref_mv        <= cfg_data[12:0];
        bcadc_pkg::REG_DIVIDER_Q8:     cfg_r.divider_q8     <= cfg_data;
        bcadc_pkg::REG_ADC_FULL_SCALE: cfg_r.adc_full_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  bcadc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (acc),
    .in_sample (in_adc_sample),
    .cfg       (cfg_r),
    .out_vld   (sc_vld),
    .out_num   (sc_num),
    .out_den   (sc_den)
  );

  bcadc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sc_vld),
    .in_num  (sc_num),
    .in_den  (sc_den),
    .out_vld (dv_vld),
    .out_mv  (dv_mv)
  );

  bcadc_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (dv_vld),
    .in_mv      (dv_mv),
    .chemistry  (cfg_r.chemistry),
    .out_vld    (out_strobe),
    .out_charge (out_charge_q8),
    .out_mv     (out_cell_millivolts),
    .out_status (out_range_status)
  );

endmodule

// File: sv/bcadc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcadc_checker
// Port-level checks of the battery charge estimator.
// ----------------------------------------------------------------------------
module bcadc_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         busy,
  input  logic         out_strobe,
  input  logic [14:0]  out_charge_q8,
  input  logic [1:0]   out_range_status
);

  // Every transaction gives a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(bcadc_pkg::LATENCY) out_strobe)
    else $error("result missing after accepted transaction");

  // Below the curve reads as empty
  a_below: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_range_status == bcadc_pkg::RANGE_BELOW) |-> out_charge_q8 == 15'd0)
    else $error("below-curve result not empty");

  // Above the curve reads as full
  a_above: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_range_status == bcadc_pkg::RANGE_ABOVE)
      |-> out_charge_q8 == bcadc_pkg::FULL_Q8)
    else $error("above-curve result not full");

  // Charge never exceeds full
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_charge_q8 <= bcadc_pkg::FULL_Q8)
    else $error("charge beyond full scale");

endmodule

bind battery_charge_from_adc bcadc_checker u_bcadc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_charge_q8    (out_charge_q8),
  .out_range_status (out_range_status)
);

// File: tb/battery_charge_from_adc_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_from_adc_test
// Self-checking bench for the battery charge estimator: directed corner
// samples and random samples under several register settings, each result
// compared field by field with a predicted charge, cell voltage and range.
// ----------------------------------------------------------------------------
module battery_charge_from_adc_test;

  typedef struct {
    logic [14:0]          charge;
    logic [15:0]          mv;
    bcadc_pkg::range_t    status;
  } soc_t;

  // Local copy of the discharge curves
  localparam int NPT = 13;
  int unsigned cmv [0:6][0:NPT-1] = '{
    '{2500,2600,2800,3000,3200,3400,3600,3800,3900,4000,4100,4150,4200},
    '{2500,2600,2800,3000,3200,3400,3600,3800,3900,4000,4100,4150,4200},
    '{900,950,1000,1050,1100,1150,1200,1250,1300,1350,1400,1450,0},
    '{900,950,1000,1050,1100,1150,1200,1250,1300,1350,0,0,0},
    '{1750,1800,1850,1900,1950,2000,2050,2100,2200,2270,0,0,0},
    '{800,850,900,950,1000,1100,1200,1300,1400,1500,1600,1650,0},
    '{800,850,900,950,1000,1100,1200,1300,1400,1500,1600,1650,0}};
  int unsigned cpct [0:6][0:NPT-1] = '{
    '{0,5,10,15,25,40,60,75,85,92,96,99,100},
    '{0,5,10,15,25,40,60,75,85,92,96,99,100},
    '{0,10,20,30,40,50,60,70,80,90,95,100,0},
    '{0,10,20,30,40,50,60,70,85,100,0,0,0},
    '{0,10,20,30,40,50,60,70,90,100,0,0,0},
    '{0,5,10,15,25,40,60,75,85,92,96,100,0},
    '{0,5,10,15,25,40,60,75,85,92,96,100,0}};
  int unsigned clen [0:6] = '{13,13,12,10,10,12,12};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_adc_sample = '0;
  logic        out_strobe;
  logic [14:0] out_charge_q8;
  logic [15:0] out_cell_millivolts;
  logic [1:0]  out_range_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predictor copy of the registers
  logic [2:0]  m_chem;
  logic [4:0]  m_cells;
  logic [12:0] m_vref;
  logic [15:0] m_div;
  logic [15:0] m_fs;

  logic [15:0] sample_q[$];
  soc_t        expect_q[$];
  int          mismatches = 0;
  int          n_results = 0;
  bit          hold_off = 1'b0;

  battery_charge_from_adc i_dut (.*);

  always #1 clk = ~clk;

  // Work out charge, voltage and range for one sample
  function automatic soc_t predict_soc(logic [15:0] s);
    soc_t r;
    logic [63:0] num, den, q;
    int unsigned v, sel, v1, v2, p1, p2;
    bit found;
    num = 64'(s) * m_vref * m_div;
    den = 64'd256 * m_fs * m_cells;
    if (den == 0) v = 65535;
    else begin
      q = num / den;
      v = (q > 65535) ? 65535 : int'(q);
    end
    sel = (m_chem >= 7) ? 0 : m_chem;
    found = 1'b0;
    r.charge = '0;
    r.status = bcadc_pkg::RANGE_ON;
    for (int i = 0; i + 1 < clen[sel] && !found; i++) begin
      v1 = cmv[sel][i];
      v2 = cmv[sel][i+1];
      if (v >= v1 && v <= v2 && v2 > v1) begin
        p1 = cpct[sel][i];
        p2 = cpct[sel][i+1];
        r.charge = 15'(p1 * 256 + ((v - v1) * (p2 - p1) * 256) / (v2 - v1));
        found = 1'b1;
      end
    end
    if (!found) begin
      if (v < cmv[sel][0]) begin
        r.charge = '0;
        r.status = bcadc_pkg::RANGE_BELOW;
      end else begin
        r.charge = bcadc_pkg::FULL_Q8;
        r.status = bcadc_pkg::RANGE_ABOVE;
      end
    end
    r.mv = 16'(v);
    return r;
  endfunction

  // Drive samples in bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && !hold_off && sample_q.size() > 0 && gap_left == 0) begin
      start <= 1'b1;
      in_adc_sample <= sample_q[0];
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end else begin
      start <= 1'b0;
      in_adc_sample <= 16'($urandom);
      if (gap_left > 0) gap_left--;
    end
  end

  // Predict on each accepted transaction, check each strobed result
  always @(posedge clk) begin
    soc_t e;
    if (rst_n && start && !busy) begin
      expect_q.push_back(predict_soc(in_adc_sample));
      void'(sample_q.pop_front());
    end
    if (rst_n && out_strobe) begin
      n_results++;
      if (expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
      end else begin
        e = expect_q.pop_front();
        if (out_charge_q8 !== e.charge || out_cell_millivolts !== e.mv ||
            out_range_status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp charge %0d mv %0d range %0d, got %0d %0d %0d",
                     e.charge, e.mv, e.status, out_charge_q8,
                     out_cell_millivolts, out_range_status);
        end
      end
    end
  end

  task automatic wait_drained();
    while (sample_q.size() > 0 || expect_q.size() > 0) @(posedge clk);
    repeat (bcadc_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(bcadc_pkg::reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bcadc_pkg::REG_CHEMISTRY:      m_chem  = val[2:0];
      bcadc_pkg::REG_CELL_COUNT:     m_cells = val[4:0];
      bcadc_pkg::REG_VREF_MV:        m_vref  = val[12:0];
      bcadc_pkg::REG_DIVIDER_Q8:     m_div   = val;
      bcadc_pkg::REG_ADC_FULL_SCALE: m_fs    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Setting that maps the full sample range to 0..65535 mV, one cell
  task automatic unity_setting(logic [2:0] chem);
    write_reg(bcadc_pkg::REG_CHEMISTRY, 16'(chem));
    write_reg(bcadc_pkg::REG_CELL_COUNT, 16'd1);
    write_reg(bcadc_pkg::REG_VREF_MV, 16'd4096);
    write_reg(bcadc_pkg::REG_DIVIDER_Q8, 16'd256);
    write_reg(bcadc_pkg::REG_ADC_FULL_SCALE, 16'd4096);
  endtask

  task automatic random_setting();
    write_reg(bcadc_pkg::REG_CHEMISTRY, 16'($urandom_range(0, 7)));
    write_reg(bcadc_pkg::REG_CELL_COUNT,
              16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                  : $urandom_range(1, 4)));
    write_reg(bcadc_pkg::REG_VREF_MV,
              16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1000, 5000)));
    write_reg(bcadc_pkg::REG_DIVIDER_Q8,
              16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(256, 2048)));
    write_reg(bcadc_pkg::REG_ADC_FULL_SCALE,
              16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1023, 65535)));
  endtask

  initial begin
    int unsigned pt;
    m_chem = 3'd0; m_cells = 5'd1; m_vref = 13'd3300; m_div = 16'd256; m_fs = 16'd4095;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: default setting, sample extremes
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'hFFFF);
    sample_q.push_back(16'd3102);
    wait_drained();

    // Directed: every chemistry on breakpoints, off both ends, with unknown code
    for (int c = 0; c < 8; c++) begin
      unity_setting(3'(c));
      pt = (c == 7) ? 0 : c;
      sample_q.push_back(16'(cmv[pt][0] - 1));
      sample_q.push_back(16'(cmv[pt][1]));
      sample_q.push_back(16'(cmv[pt][clen[pt]-1]));
      sample_q.push_back(16'(cmv[pt][clen[pt]-1] + 1));
      hold_off = 1'b0;
      wait_drained();
    end

    // Directed: zero divisors and the register extremes
    write_reg(bcadc_pkg::REG_CELL_COUNT, 16'd0);
    sample_q.push_back(16'd5);
    wait_drained();
    write_reg(bcadc_pkg::REG_CELL_COUNT, 16'd31);
    write_reg(bcadc_pkg::REG_ADC_FULL_SCALE, 16'd0);
    sample_q.push_back(16'd0);
    wait_drained();
    write_reg(bcadc_pkg::REG_ADC_FULL_SCALE, 16'hFFFF);
    write_reg(bcadc_pkg::REG_VREF_MV, 16'hFFFF);
    write_reg(bcadc_pkg::REG_DIVIDER_Q8, 16'hFFFF);
    sample_q.push_back(16'hFFFF);
    sample_q.push_back(16'h5555);
    wait_drained();

    // Random phases: every third phase mostly on-curve voltages, the rest raw noise
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0) unity_setting(3'($urandom_range(0, 7)));
      else random_setting();
      pt = (m_chem == 7) ? 0 : m_chem;
      for (int k = 0; k < 70; k++) begin
        if (ph % 3 == 0 && $urandom_range(0, 3) != 0)
          sample_q.push_back(16'($urandom_range(cmv[pt][0] - 20, cmv[pt][clen[pt]-1] + 20)));
        else
          sample_q.push_back(16'($urandom));
        // Pause the sender once until every pending result has come back
        if (ph == 4 && k == 35) begin
          hold_off = 1'b1;
          @(posedge clk);
          while (expect_q.size() > 0) @(posedge clk);
          hold_off = 1'b0;
        end
      end
      wait_drained();
    end

    $display("Checked %0d results over all chemistries, zero divisors and register extremes",
             n_results);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
sv/bcadc_pkg.sv
sv/bcadc_scale.sv
sv/bcadc_div.sv
sv/bcadc_interp.sv
sv/battery_charge_from_adc.sv
sv/bcadc_checker.sv
tb/battery_charge_from_adc_test.sv
